// ----- hw/rtl/jsu_pkg.sv -----
// Shared types and constants for the JSON string unescape unit.
`default_nettype none
package jsu_pkg;

   localparam int QDepth = 4;
   localparam int QPtrW  = $clog2(QDepth);
   localparam int QCntW  = $clog2(QDepth + 1);

   typedef enum logic [2:0] {
      ST_DATA   = 3'd0,
      ST_DONE   = 3'd1,
      ST_NOTSTR = 3'd2,
      ST_UNTERM = 3'd3,
      ST_BADHEX = 3'd4,
      ST_BADESC = 3'd5,
      ST_BADCTL = 3'd6
   } status_type;

   // One queue entry: up to three result bytes produced by one request.
   typedef struct packed {
      logic [1:0] last_idx;
      logic [7:0] byte2;
      logic [7:0] byte1;
      logic [7:0] byte0;
      status_type status;
   } entry_type;

   typedef struct packed {
      logic             full;
      logic             empty;
      logic [QCntW-1:0] count;
   } qstat_type;

endpackage
`default_nettype wire

// ----- hw/rtl/jsu_front.sv -----
// Front end: parses request bytes and classifies them into queue entries.
`default_nettype none
module jsu_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [7:0]         req_tdata,  // in_byte
   input  wire logic               req_tuser,  // start_flag
   input  wire jsu_pkg::qstat_type q_stat,
   output logic                    push,
   output jsu_pkg::entry_type      push_entry
);
   import jsu_pkg::*;

   typedef enum logic [7:0] {
      PH_QUOTE = 8'b0000_0001,
      PH_BODY  = 8'b0000_0010,
      PH_ESC   = 8'b0000_0100,
      PH_HEX0  = 8'b0000_1000,
      PH_HEX1  = 8'b0001_0000,
      PH_HEX2  = 8'b0010_0000,
      PH_HEX3  = 8'b0100_0000,
      PH_HALT  = 8'b1000_0000
   } phase_type;

   phase_type   phase_ff, phase_in, phase_cur;
   logic [11:0] cu_ff, cu_in;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] cu_full;
   logic        accept;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (req_tdata >= 8'h30 && req_tdata <= 8'h39) begin
         hex_val = 4'(req_tdata - 8'h30);
      end else if (req_tdata >= 8'h61 && req_tdata <= 8'h66) begin
         hex_val = 4'(req_tdata - 8'h57);
      end else if (req_tdata >= 8'h41 && req_tdata <= 8'h46) begin
         hex_val = 4'(req_tdata - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign req_tready = !q_stat.full;
   assign accept     = req_tvalid && req_tready;
   assign phase_cur  = req_tuser ? PH_QUOTE : phase_ff;
   assign cu_full    = {cu_ff, hex_val};

   always_comb begin
      phase_in   = phase_cur;
      cu_in      = cu_ff;
      push       = 1'b0;
      push_entry = '{last_idx: 2'd0, byte2: 8'h00, byte1: 8'h00, byte0: 8'h00,
                     status: ST_DATA};
      case (phase_cur)
         PH_QUOTE: begin
            if (req_tdata == 8'h22) begin
               phase_in = PH_BODY;
            end else begin
               phase_in = PH_HALT;
               push = 1'b1;
               push_entry.status = ST_NOTSTR;
            end
         end
         PH_BODY: begin
            push = 1'b1;
            if (req_tdata == 8'h22) begin
               phase_in = PH_HALT;
               push_entry.status = ST_DONE;
            end else if (req_tdata == 8'h00) begin
               phase_in = PH_HALT;
               push_entry.status = ST_UNTERM;
            end else if (req_tdata == 8'h5C) begin
               phase_in = PH_ESC;
               push = 1'b0;
            end else if (req_tdata < 8'h20) begin
               phase_in = PH_HALT;
               push_entry.status = ST_BADCTL;
            end else begin
               push_entry.byte0 = req_tdata;
            end
         end
         PH_ESC: begin
            push = 1'b1;
            phase_in = PH_BODY;
            case (req_tdata)
               8'h00: begin
                  phase_in = PH_HALT;
                  push_entry.status = ST_UNTERM;
               end
               8'h22, 8'h5C, 8'h2F: push_entry.byte0 = req_tdata;
               8'h62: push_entry.byte0 = 8'h08;
               8'h66: push_entry.byte0 = 8'h0C;
               8'h6E: push_entry.byte0 = 8'h0A;
               8'h72: push_entry.byte0 = 8'h0D;
               8'h74: push_entry.byte0 = 8'h09;
               8'h75: begin
                  push = 1'b0;
                  phase_in = PH_HEX0;
                  cu_in = 12'd0;
               end
               default: begin
                  phase_in = PH_HALT;
                  push_entry.status = ST_BADESC;
               end
            endcase
         end
         PH_HEX0, PH_HEX1, PH_HEX2, PH_HEX3: begin
            if (!hex_ok) begin
               phase_in = PH_HALT;
               push = 1'b1;
               push_entry.status = ST_BADHEX;
            end else if (phase_cur != PH_HEX3) begin
               cu_in = {cu_ff[7:0], hex_val};
               case (phase_cur)
                  PH_HEX0: phase_in = PH_HEX1;
                  PH_HEX1: phase_in = PH_HEX2;
                  default: phase_in = PH_HEX3;
               endcase
            end else begin
               phase_in = PH_BODY;
               push = 1'b1;
               if (cu_full[15:7] == 9'd0) begin
                  push_entry.byte0 = cu_full[7:0];
               end else if (cu_full[15:11] == 5'd0) begin
                  push_entry.last_idx = 2'd1;
                  push_entry.byte0 = 8'hC0 | {3'b000, cu_full[10:6]};
                  push_entry.byte1 = 8'h80 | {2'b00, cu_full[5:0]};
               end else begin
                  push_entry.last_idx = 2'd2;
                  push_entry.byte0 = 8'hE0 | {4'b0000, cu_full[15:12]};
                  push_entry.byte1 = 8'h80 | {2'b00, cu_full[11:6]};
                  push_entry.byte2 = 8'h80 | {2'b00, cu_full[5:0]};
               end
            end
         end
         default: begin
            phase_in = PH_HALT;
         end
      endcase
      if (!accept) begin
         phase_in = phase_ff;
         cu_in = cu_ff;
         push = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_QUOTE;
      end else begin
         phase_ff <= phase_in;
      end
      cu_ff <= cu_in;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/jsu_queue.sv -----
// Small register queue between the front and back ends.
`default_nettype none
module jsu_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire jsu_pkg::entry_type push_entry,
   input  wire logic               pop,
   output jsu_pkg::entry_type      head,
   output jsu_pkg::qstat_type      q_stat
);
   import jsu_pkg::*;

   entry_type        mem_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_stat.count = count_ff;
   assign q_stat.full  = (count_ff == QCntW'(QDepth));
   assign q_stat.empty = (count_ff == '0);
   assign head         = mem_ff[rd_ptr_ff];

   assign do_push = push && !q_stat.full;
   assign do_pop  = pop && !q_stat.empty;

   always_comb begin
      wr_ptr_in = do_push ? QPtrW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QPtrW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = QCntW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = QCntW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/jsu_back.sv -----
// Back end: unpacks entries, a byte per cycle unless stalled.
`default_nettype none
module jsu_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire jsu_pkg::entry_type head,
   input  wire jsu_pkg::qstat_type q_stat,
   output logic                    pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [7:0]              rsp_byte,
   output jsu_pkg::status_type     rsp_status,
   output logic                    rsp_tlast
);
   import jsu_pkg::*;

   entry_type  cur_ff, cur_in;
   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       fire;

   assign rsp_tvalid = valid_ff;
   assign rsp_status = cur_ff.status;
   assign rsp_tlast  = (idx_ff == cur_ff.last_idx);
   assign fire       = valid_ff && rsp_tready;

   always_comb begin
      case (idx_ff)
         2'd0:    rsp_byte = cur_ff.byte0;
         2'd1:    rsp_byte = cur_ff.byte1;
         default: rsp_byte = cur_ff.byte2;
      endcase
   end

   assign pop = !q_stat.empty && (!valid_ff || (fire && rsp_tlast));

   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (pop) begin
         cur_in   = head;
         valid_in = 1'b1;
         idx_in   = 2'd0;
      end else if (fire) begin
         if (rsp_tlast) begin
            valid_in = 1'b0;
         end else begin
            idx_in = 2'(idx_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
      cur_ff <= cur_in;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/json_string_unescape_utf8_unit.sv -----
// A request goes into a four-entry queue that decouples parsing from output,
// then into the back-end output register. Throughput: one request per cycle while the
// queue has room; a \u escape emits up to three bytes, one per cycle unless stalled.
// Reset: synchronous, active high; parser expects an opening quote, queue empties.
// Requests are accepted while the queue has room, independent of response stalls.
`default_nettype none
module json_string_unescape_utf8_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,  // [7:0] in_byte
   input  wire logic        req_tuser,  // [0] start_flag
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // [7:0] out_byte, [10:8] status, [15:11] zero
   output logic             rsp_tlast   // last_of_run
);
   import jsu_pkg::*;

   qstat_type  q_stat;
   entry_type  push_entry, head;
   logic       push, pop;
   logic [7:0] rsp_byte;
   status_type rsp_status;

   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   jsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_byte   (rsp_byte),
      .rsp_status (rsp_status),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = {5'b00000, rsp_status, rsp_byte};

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10:8] != 3'd7)
      else $error("response status out of range");

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status != ST_DATA) |-> (rsp_byte == 8'h00 && rsp_tlast))
      else $error("non-data response must be a zero byte ending its run");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCntW'(QDepth))
      else $error("queue count exceeds depth");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid && q_stat.empty) |=> !rsp_tvalid)
      else $error("response appeared with nothing queued");

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for json_string_unescape_utf8_unit: byte stream stimulus and a scoreboard.
`timescale 1ns / 1ps

import jsu_pkg::*;

localparam logic [7:0] CH_QUOTE  = 8'h22;
localparam logic [7:0] CH_BSLASH = 8'h5C;
localparam logic [7:0] CH_U      = 8'h75;

typedef enum logic [3:0] {
   WAIT_QUOTE, IN_TEXT, AFTER_BSLASH, HEX_1, HEX_2, HEX_3, HEX_4, HALTED
} parse_phase_type;

typedef struct packed {
   logic [7:0] data;
   status_type status;
   logic       last;
} decoded_type;

function automatic int hex_value(logic [7:0] b);
   if (b >= 8'h30 && b <= 8'h39) return int'(b) - 48;
   if (b >= 8'h61 && b <= 8'h66) return int'(b) - 87;
   if (b >= 8'h41 && b <= 8'h46) return int'(b) - 55;
   return -1;
endfunction

// {valid, byte} for single-character escapes
function automatic logic [8:0] escape_value(logic [7:0] b);
   case (b)
      CH_QUOTE, CH_BSLASH, 8'h2F: begin
         return {1'b1, b};
      end
      8'h62: return 9'h108;
      8'h66: return 9'h10C;
      8'h6E: return 9'h10A;
      8'h72: return 9'h10D;
      8'h74: return 9'h109;
      default: return 9'h000;
   endcase
endfunction

class unescape_scoreboard;
   parse_phase_type phase;
   logic [15:0]     code_unit;
   decoded_type     decoded_q[$];
   int              errors;

   function new();
      phase     = WAIT_QUOTE;
      code_unit = '0;
      errors    = 0;
   endfunction

   function void emit(logic [7:0] b, status_type st, logic last);
      decoded_type d;
      d.data   = b;
      d.status = st;
      d.last   = last;
      decoded_q.push_back(d);
   endfunction

   function void halt(status_type st);
      emit(8'h00, st, 1'b1);
      phase = HALTED;
   endfunction

   // Returns 1 when the parser is halted and the request is dropped.
   function bit note_request(logic [7:0] b, logic start);
      int         d;
      logic [8:0] e;
      bit         dropped;
      if (start) begin
         phase     = WAIT_QUOTE;
         code_unit = '0;
      end
      dropped = (phase == HALTED);
      case (phase)
         WAIT_QUOTE: begin
            if (b == CH_QUOTE) phase = IN_TEXT;
            else halt(ST_NOTSTR);
         end
         IN_TEXT: begin
            if (b == CH_QUOTE) halt(ST_DONE);
            else if (b == 8'h00) halt(ST_UNTERM);
            else if (b == CH_BSLASH) phase = AFTER_BSLASH;
            else if (b < 8'h20) halt(ST_BADCTL);
            else emit(b, ST_DATA, 1'b1);
         end
         AFTER_BSLASH: begin
            e = escape_value(b);
            if (b == 8'h00) halt(ST_UNTERM);
            else if (b == CH_U) begin
               code_unit = '0;
               phase     = HEX_1;
            end else if (e[8]) begin
               emit(e[7:0], ST_DATA, 1'b1);
               phase = IN_TEXT;
            end else halt(ST_BADESC);
         end
         HEX_1, HEX_2, HEX_3, HEX_4: begin
            d = hex_value(b);
            if (d < 0) halt(ST_BADHEX);
            else begin
               code_unit = {code_unit[11:0], d[3:0]};
               if (phase != HEX_4) phase = parse_phase_type'(phase + 1);
               else begin
                  // surrogates are encoded on their own, three bytes
                  if (code_unit <= 16'h007F) begin
                     emit(code_unit[7:0], ST_DATA, 1'b1);
                  end else if (code_unit <= 16'h07FF) begin
                     emit({3'b110, code_unit[10:6]}, ST_DATA, 1'b0);
                     emit({2'b10, code_unit[5:0]}, ST_DATA, 1'b1);
                  end else begin
                     emit({4'b1110, code_unit[15:12]}, ST_DATA, 1'b0);
                     emit({2'b10, code_unit[11:6]}, ST_DATA, 1'b0);
                     emit({2'b10, code_unit[5:0]}, ST_DATA, 1'b1);
                  end
                  phase = IN_TEXT;
               end
            end
         end
         default: ;
      endcase
      return dropped;
   endfunction

   function void check_response(logic [15:0] tdata, logic tlast);
      decoded_type want;
      if (decoded_q.size() == 0) begin
         errors++;
         $display("%0t: unexpected response, expected none, actual byte %02h status %0d %s %0b",
                  $time, tdata[7:0], tdata[10:8], "last", tlast);
         return;
      end
      want = decoded_q.pop_front();
      if (tdata[7:0] !== want.data) begin
         errors++;
         $display("%0t: out_byte expected %02h actual %02h", $time, want.data, tdata[7:0]);
      end
      if (tdata[10:8] !== want.status) begin
         errors++;
         $display("%0t: status expected %0d actual %0d", $time, want.status, tdata[10:8]);
      end
      if (tlast !== want.last) begin
         errors++;
         $display("%0t: last_of_run expected %0b actual %0b", $time, want.last, tlast);
      end
   endfunction
endclass

module tb;
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;  // [7:0] in_byte
   logic        req_tuser  = 1'b0;   // [0] start_flag
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [7:0] out_byte, [10:8] status, [15:11] zero
   logic        rsp_tlast;           // last_of_run

   bit req_idle_on  = 1'b1;
   bit rsp_idle_on  = 1'b1;
   int active_count = 0;

   logic [7:0] escape_letters [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74};

   unescape_scoreboard sb = new;

   json_string_unescape_utf8_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= !rsp_idle_on || ($urandom_range(99) >= 22);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tlast);
   end

   task automatic send_byte(logic [7:0] b, logic start);
      // quiet stretch: no gaps and no stalls
      req_idle_on = !(active_count >= 200 && active_count < 300);
      rsp_idle_on = req_idle_on;
      while (req_idle_on && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         req_tuser  <= 1'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= start;
      do @(posedge clock); while (!req_tready);
      if (!sb.note_request(b, start)) active_count++;
   endtask

   function automatic logic [7:0] hex_char(logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
   endfunction

   task automatic send_random_string();
      logic [7:0]  txt[$];
      logic [7:0]  b;
      logic [15:0] cu;
      logic [8:0]  e;
      int          i;
      txt.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 10)) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
               do b = 8'($urandom_range(32, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
               txt.push_back(b);
            end
            6, 7: begin
               txt.push_back(CH_BSLASH);
               txt.push_back(escape_letters[$urandom_range(7)]);
            end
            default: begin
               case ($urandom_range(4))
                  0: cu = 16'($urandom_range(16'h0000, 16'h007F));
                  1: cu = 16'($urandom_range(16'h0080, 16'h07FF));
                  2: cu = 16'($urandom_range(16'hD800, 16'hDFFF));
                  3: cu = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
                  default: cu = 16'($urandom);
               endcase
               txt.push_back(CH_BSLASH);
               txt.push_back(CH_U);
               for (i = 3; i >= 0; i--) txt.push_back(hex_char(cu[i*4 +: 4]));
            end
         endcase
      end
      if ($urandom_range(99) < 80) begin
         txt.push_back(CH_QUOTE);
      end else begin
         case ($urandom_range(4))
            0: txt.push_back(8'h00);
            1: txt.push_back(8'($urandom_range(1, 31)));
            2: begin
               txt.push_back(CH_BSLASH);
               do begin
                  b = 8'($urandom);
                  e = escape_value(b);
               end while (e[8] || b == CH_U);
               txt.push_back(b);
            end
            default: begin
               txt.push_back(CH_BSLASH);
               txt.push_back(CH_U);
               repeat ($urandom_range(0, 3)) txt.push_back(hex_char(4'($urandom)));
               do b = 8'($urandom); while (hex_value(b) >= 0);
               txt.push_back(b);
            end
         endcase
      end
      // trailing bytes after the end are dropped until the next start
      repeat ($urandom_range(0, 2)) txt.push_back(8'($urandom));
      foreach (txt[k]) send_byte(txt[k], k == 0);
   endtask

   initial begin
      int directed_end;
      int i;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // first byte after reset, no start flag
      send_byte(CH_QUOTE, 1'b0);
      send_byte(8'h20, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(CH_BSLASH, 1'b0);
      send_byte(CH_U, 1'b0);
      send_byte("0", 1'b0);
      send_byte("7", 1'b0);
      send_byte("f", 1'b0);
      send_byte("F", 1'b0);
      send_byte(CH_QUOTE, 1'b0);
      send_byte("x", 1'b0);
      // no opening quote
      send_byte("x", 1'b1);
      // control byte in body
      send_byte(CH_QUOTE, 1'b1);
      send_byte(8'h1F, 1'b0);
      // zero in body
      send_byte(CH_QUOTE, 1'b1);
      send_byte(8'h00, 1'b0);
      // zero after backslash
      send_byte(CH_QUOTE, 1'b1);
      send_byte(CH_BSLASH, 1'b0);
      send_byte(8'h00, 1'b0);
      // control byte as escape letter
      send_byte(CH_QUOTE, 1'b1);
      send_byte(CH_BSLASH, 1'b0);
      send_byte(8'h01, 1'b0);
      // zero in a hex position
      send_byte(CH_QUOTE, 1'b1);
      send_byte(CH_BSLASH, 1'b0);
      send_byte(CH_U, 1'b0);
      send_byte(8'h00, 1'b0);
      directed_end = active_count;

      while (active_count < directed_end + 480) begin
         if ($urandom_range(99) < 80) begin
            send_random_string();
         end else begin
            send_byte(8'($urandom), 1'b1);
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom), $urandom_range(3) == 0);
         end
      end
      req_tvalid <= 1'b0;

      for (i = 0; i < 5000 && sb.decoded_q.size() != 0; i++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.decoded_q.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, sb.decoded_q.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end
endmodule

// ----- files.f -----
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_front.sv
hw/rtl/jsu_queue.sv
hw/rtl/jsu_back.sv
hw/rtl/json_string_unescape_utf8_unit.sv
bench/tb.sv
